/* src/assert_macros.svh */
// Assertion macros used by the RTL file that checks itself.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that cond is followed by conseq at the next rising edge of clk.
`define ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

/* src/skvt_pkg.sv */
// Types and codes of the sorted key/value table.
// No dependencies; skvt_cell, the core and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package skvt_pkg;

    localparam int KEY_W   = 32;
    localparam int NAME_W  = 64;
    localparam int VALUE_W = 32;

    localparam logic [2:0] MODE_INSERT = 3'd0;
    localparam logic [2:0] MODE_DELETE = 3'd1;
    localparam logic [2:0] MODE_UPDATE = 3'd2;
    localparam logic [2:0] MODE_SEARCH = 3'd3;
    localparam logic [2:0] MODE_DUMP   = 3'd4;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
    localparam logic [2:0] STATUS_NOT_FOUND = 3'd2;
    localparam logic [2:0] STATUS_FULL      = 3'd3;
    localparam logic [2:0] STATUS_EMPTY     = 3'd4;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [NAME_W-1:0]  name;
        logic [VALUE_W-1:0] value;
    } rec_t;

    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic del_en;
        logic upd_en;
        rec_t rec;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* src/skvt_req_if.sv */
// Request channel of the sorted key/value table: valid, ready and payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface skvt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [31:0] key;
    logic [63:0] name;
    logic [31:0] value;

    modport source (output valid, mode, key, name, value, input ready);
    modport sink   (input valid, mode, key, name, value, output ready);
endinterface

`default_nettype wire

/* src/skvt_rsp_if.sv */
// Response channel of the sorted key/value table: valid, ready and payload.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface skvt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] key_out;
    logic [63:0] name_out;
    logic [31:0] value_out;
    logic [31:0] old_value;
    logic        last;

    modport source (output valid, status, key_out, name_out, value_out, old_value, last,
                    input ready);
    modport sink   (input valid, status, key_out, name_out, value_out, old_value, last,
                    output ready);
endinterface

`default_nettype wire

/* src/skvt_cell.sv */
// One slot of the sorted table: holds a record, compares it with the search key, shifts records
// to and from its neighbors and rewrites its value on update. Depends on skvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module skvt_cell
    import skvt_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occ,
    input  wire logic       left_lt,
    input  wire rec_t       left_rec,
    input  wire rec_t       right_rec,
    output rec_t            rec,
    output logic            lt,
    output logic            eq
);

    rec_t rec_reg;
    rec_t rec_next;
    logic lt_reg;
    logic eq_reg;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctrl.ins_en && !lt_reg)
        begin
            rec_next = left_lt ? ctrl.rec : left_rec;
        end
        else if (ctrl.del_en && !lt_reg)
        begin
            rec_next = right_rec;
        end
        else if (ctrl.upd_en && eq_reg)
        begin
            rec_next.value = ctrl.rec.value;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        if (ctrl.cmp_en)
        begin
            lt_reg <= occ && (rec_reg.key < ctrl.rec.key);
            eq_reg <= occ && (rec_reg.key == ctrl.rec.key);
        end
    end

    assign rec = rec_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

`default_nettype wire

/* src/sorted_key_value_table_core.sv */
// Sorted key/value table: a row of compare-and-shift cells with a small sequencer.
// Depends on skvt_pkg, skvt_req_if, skvt_rsp_if, skvt_cell and assert_macros.svh.
//
// Usage:
//   req carries one operation per beat: insert, delete, update, search or dump.
//   rsp carries the result beats; last marks the final beat of an operation.
//   Insert, delete, update and search give one beat; dump gives one beat per
//   record in ascending key order, or a single table-empty beat.
//   Unused mode codes are taken and dropped without a result.
// Timing: each operation passes through a compare step, in which all cells compare
//   against the key in parallel, and an execute step, in which they shift or rewrite
//   in place and the result beat is registered; the next request can be taken in that step.
//   A dump then moves one record per clock while the output register is free.
// Reset empties the table; record storage is not cleared.
// When rsp stalls, the held beat stays put; the next operation is still taken
//   and waits in its execute step until the output register frees.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sorted_key_value_table_core
    import skvt_pkg::*;
#(
    parameter int TABLE_DEPTH = 32,
    parameter int NAME_BYTES  = 8
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    skvt_req_if.sink  req,
    skvt_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC,
        ST_DUMP
    } state_t;

    state_t              state_reg;
    logic [2:0]          mode_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [NAME_W-1:0]   name_reg;
    logic [VALUE_W-1:0]  value_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                out_valid_reg;
    logic [2:0]          out_status_reg;
    rec_t                out_rec_reg;
    logic [VALUE_W-1:0]  out_old_reg;
    logic                out_last_reg;

    rec_t                cell_rec [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] cell_lt;
    logic [TABLE_DEPTH-1:0] cell_eq;
    logic [TABLE_DEPTH-1:0] occ;
    logic [TABLE_DEPTH-1:0] sel;
    cell_ctrl_t          ctrl;
    rec_t                sel_rec;
    logic [NAME_W-1:0]   kept_name;

    logic                found;
    logic                full;
    logic                slot_free;
    logic                exec_go;
    logic                dump_go;
    logic                dump_start;
    logic                req_fire;
    logic                dump_last;

    logic [2:0]          res_status;
    rec_t                res_rec;
    logic [VALUE_W-1:0]  res_old;
    logic                res_last;

    // Keep bytes up to the first zero byte, at most NAME_BYTES-1 of them.
    always_comb
    begin
        logic stop;
        stop      = 1'b0;
        kept_name = '0;
        for (int b = 0; b < 8; b++)
        begin
            if (b < NAME_BYTES - 1 && !stop && name_reg[8*b +: 8] != 8'd0)
            begin
                kept_name[8*b +: 8] = name_reg[8*b +: 8];
            end
            else
            begin
                stop = 1'b1;
            end
        end
    end

    assign found      = |cell_eq;
    assign full       = (count_reg == CNT_W'(TABLE_DEPTH));
    assign slot_free  = !out_valid_reg || rsp.ready;
    assign exec_go    = (state_reg == ST_EXEC) && slot_free;
    assign dump_go    = (state_reg == ST_DUMP) && slot_free;
    assign dump_start = (mode_reg == MODE_DUMP) && (count_reg != '0);
    assign dump_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    assign req.ready = (state_reg == ST_IDLE) || (exec_go && !dump_start);
    assign req_fire  = req.valid && req.ready;

    assign ctrl.cmp_en = (state_reg == ST_CMP);
    assign ctrl.ins_en = exec_go && (mode_reg == MODE_INSERT) && !found && !full;
    assign ctrl.del_en = exec_go && (mode_reg == MODE_DELETE) && found;
    assign ctrl.upd_en = exec_go && (mode_reg == MODE_UPDATE) && found;
    assign ctrl.rec    = '{key: key_reg, name: kept_name, value: value_reg};

    genvar i;
    generate
        for (i = 0; i < TABLE_DEPTH; i++)
        begin : g_cell
            rec_t left_rec;
            rec_t right_rec;
            logic left_lt;

            assign occ[i] = (CNT_W'(i) < count_reg);
            assign sel[i] = (state_reg == ST_DUMP) ? (idx_reg == IDX_W'(i)) : cell_eq[i];

            if (i == 0)
            begin : g_first
                assign left_rec = ctrl.rec;
                assign left_lt  = 1'b1;
            end
            else
            begin : g_mid
                assign left_rec = cell_rec[i-1];
                assign left_lt  = cell_lt[i-1];
            end

            if (i == TABLE_DEPTH - 1)
            begin : g_last
                assign right_rec = cell_rec[i];
            end
            else
            begin : g_inner
                assign right_rec = cell_rec[i+1];
            end

            skvt_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occ       (occ[i]),
                .left_lt   (left_lt),
                .left_rec  (left_rec),
                .right_rec (right_rec),
                .rec       (cell_rec[i]),
                .lt        (cell_lt[i]),
                .eq        (cell_eq[i])
            );
        end
    endgenerate

    always_comb
    begin
        sel_rec = '0;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            if (sel[k])
            begin
                sel_rec = sel_rec | cell_rec[k];
            end
        end
    end

    always_comb
    begin
        res_status = STATUS_OK;
        res_rec    = sel_rec;
        res_old    = '0;
        res_last   = 1'b1;
        if (state_reg == ST_DUMP)
        begin
            res_last = dump_last;
        end
        else
        begin
            case (mode_reg) inside
                MODE_INSERT:
                begin
                    if (found)
                    begin
                        res_status = STATUS_DUPLICATE;
                    end
                    else if (full)
                    begin
                        res_status = STATUS_FULL;
                        res_rec    = '{key: key_reg, name: '0, value: '0};
                    end
                    else
                    begin
                        res_rec = ctrl.rec;
                    end
                end
                MODE_DELETE, MODE_SEARCH, MODE_UPDATE:
                begin
                    if (!found)
                    begin
                        res_status = STATUS_NOT_FOUND;
                        res_rec    = '{key: key_reg, name: '0, value: '0};
                    end
                    else if (mode_reg == MODE_UPDATE)
                    begin
                        res_rec.value = value_reg;
                        res_old       = sel_rec.value;
                    end
                end
                default:
                begin
                    res_status = STATUS_EMPTY;
                    res_rec    = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((exec_go && !dump_start) || dump_go)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= res_status;
                out_rec_reg    <= res_rec;
                out_old_reg    <= res_old;
                out_last_reg   <= res_last;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (req_fire)
            begin
                mode_reg  <= req.mode;
                key_reg   <= req.key;
                name_reg  <= req.name;
                value_reg <= req.value;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire && req.mode <= MODE_DUMP)
                    begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    state_reg <= ST_EXEC;
                end
                ST_EXEC:
                begin
                    if (exec_go)
                    begin
                        if (ctrl.ins_en)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        else if (ctrl.del_en)
                        begin
                            count_reg <= count_reg - CNT_W'(1);
                        end

                        if (dump_start)
                        begin
                            state_reg <= ST_DUMP;
                            idx_reg   <= '0;
                        end
                        else if (req_fire && req.mode <= MODE_DUMP)
                        begin
                            state_reg <= ST_CMP;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_DUMP:
                begin
                    if (dump_go)
                    begin
                        if (dump_last)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + IDX_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.key_out   = out_rec_reg.key;
    assign rsp.name_out  = out_rec_reg.name;
    assign rsp.value_out = out_rec_reg.value;
    assign rsp.old_value = out_old_reg;
    assign rsp.last      = out_last_reg;

    `ASSERT_NEXT(a_ins_count, ctrl.ins_en, count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow the table")
    `ASSERT_NEXT(a_del_count, ctrl.del_en, count_reg == $past(count_reg) - CNT_W'(1), "delete did not shrink the table")
    `ASSERT_CLK(a_dump_nonempty, state_reg != ST_DUMP || count_reg != '0, "dump walk on an empty table")

    generate
        for (i = 0; i + 1 < TABLE_DEPTH; i++)
        begin : g_order
            `ASSERT_CLK(a_sorted, !occ[i+1] || cell_rec[i].key < cell_rec[i+1].key, "table keys out of order")
        end
    endgenerate

endmodule

`default_nettype wire

/* verif/sorted_key_value_table_core_tb.sv */
// Self-checking testbench for sorted_key_value_table_core: directed and random ops against an in-bench table.
// Depends on skvt_pkg, skvt_req_if, skvt_rsp_if and the core RTL.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_value_table_core_tb
    import skvt_pkg::*;
();

    localparam int TABLE_DEPTH  = 32;
    localparam int NAME_BYTES   = 8;
    localparam int POOL_SIZE    = 40;
    localparam int MIXED_OPS    = 130;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] key;
        logic [63:0] name;
        logic [31:0] value;
    } table_op_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] key;
        logic [63:0] name;
        logic [31:0] value;
        logic [31:0] old_value;
        logic        last;
    } table_beat_t;

    logic clk;
    logic rst_n = 1'b0;

    skvt_req_if req_bus();
    skvt_rsp_if rsp_bus();

    sorted_key_value_table_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_BYTES  (NAME_BYTES)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    table_op_t   pending_ops[$];
    table_beat_t expected_beats[$];
    rec_t        table_model[$];
    logic [31:0] key_pool[POOL_SIZE];
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left;
    int          gap_left;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] trim_name(input logic [63:0] raw);
        logic [63:0] kept;
        kept = '0;
        for (int i = 0; i < NAME_BYTES - 1; i++)
        begin
            if (raw[8*i +: 8] == 8'h00)
                break;
            kept[8*i +: 8] = raw[8*i +: 8];
        end
        return kept;
    endfunction

    function automatic void push_beat(input logic [2:0] status, input logic [31:0] key,
                                      input logic [63:0] name, input logic [31:0] value,
                                      input logic [31:0] old_value, input logic last);
        table_beat_t b;
        b.status    = status;
        b.key       = key;
        b.name      = name;
        b.value     = value;
        b.old_value = old_value;
        b.last      = last;
        expected_beats.push_back(b);
    endfunction

    function automatic void apply_op(input table_op_t op);
        int   pos;
        bit   hit;
        rec_t r;
        if (op.mode == MODE_DUMP)
        begin
            if (table_model.size() == 0)
                push_beat(STATUS_EMPTY, '0, '0, '0, '0, 1'b1);
            else
                foreach (table_model[i])
                    push_beat(STATUS_OK, table_model[i].key, table_model[i].name,
                              table_model[i].value, '0, i == table_model.size() - 1);
            return;
        end
        if (op.mode > MODE_DUMP)
            return;
        pos = 0;
        while (pos < table_model.size() && table_model[pos].key < op.key)
            pos++;
        hit = (pos < table_model.size()) && (table_model[pos].key == op.key);
        if (op.mode == MODE_INSERT)
        begin
            if (hit)
                push_beat(STATUS_DUPLICATE, op.key, table_model[pos].name,
                          table_model[pos].value, '0, 1'b1);
            else if (table_model.size() >= TABLE_DEPTH)
                push_beat(STATUS_FULL, op.key, '0, '0, '0, 1'b1);
            else
            begin
                r.key   = op.key;
                r.name  = trim_name(op.name);
                r.value = op.value;
                table_model.insert(pos, r);
                push_beat(STATUS_OK, op.key, r.name, op.value, '0, 1'b1);
            end
        end
        else if (!hit)
            push_beat(STATUS_NOT_FOUND, op.key, '0, '0, '0, 1'b1);
        else
        begin
            case (op.mode)
                MODE_DELETE:
                begin
                    push_beat(STATUS_OK, op.key, table_model[pos].name,
                              table_model[pos].value, '0, 1'b1);
                    table_model.delete(pos);
                end
                MODE_UPDATE:
                begin
                    push_beat(STATUS_OK, op.key, table_model[pos].name, op.value,
                              table_model[pos].value, 1'b1);
                    table_model[pos].value = op.value;
                end
                default:
                    push_beat(STATUS_OK, op.key, table_model[pos].name,
                              table_model[pos].value, '0, 1'b1);
            endcase
        end
    endfunction

    function automatic void check_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", field, want, got);
            error_count++;
        end
    endfunction

    function automatic void queue_op(input logic [2:0] mode, input logic [31:0] key,
                                     input logic [63:0] name, input logic [31:0] value);
        table_op_t op;
        op.mode  = mode;
        op.key   = key;
        op.name  = name;
        op.value = value;
        pending_ops.push_back(op);
    endfunction

    function automatic logic [63:0] rand_name();
        logic [63:0] n;
        int          b;
        n = {$urandom, $urandom};
        b = $urandom_range(0, 7);
        if ($urandom_range(0, 2) == 0)
            n[8*b +: 8] = 8'h00;
        return n;
    endfunction

    function automatic logic [31:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    function automatic void shuffle_order(ref int order[POOL_SIZE]);
        int j;
        int t;
        for (int i = 0; i < POOL_SIZE; i++)
            order[i] = i;
        for (int i = POOL_SIZE - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_bus.valid <= 1'b0;
            req_bus.mode  <= MODE_INSERT;
            req_bus.key   <= '0;
            req_bus.name  <= '0;
            req_bus.value <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (req_bus.valid && req_bus.ready)
                apply_op(pending_ops.pop_front());
            if (!(req_bus.valid && !req_bus.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_bus.valid <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    req_bus.valid <= 1'b1;
                    req_bus.mode  <= pending_ops[0].mode;
                    req_bus.key   <= pending_ops[0].key;
                    req_bus.name  <= pending_ops[0].name;
                    req_bus.value <= pending_ops[0].value;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            burst_left = 30;
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 6);
                            gap_left   = $urandom_range(0, 5);
                        end
                    end
                end
                else
                    req_bus.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern cycles through open, light, heavy and periodic phases.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_bus.ready <= 1'b0;
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing expected: status %0d key %h",
                           rsp_bus.status, rsp_bus.key_out);
                    error_count++;
                end
                else
                begin
                    table_beat_t want;
                    want = expected_beats.pop_front();
                    check_field("status", want.status, rsp_bus.status);
                    check_field("key_out", want.key, rsp_bus.key_out);
                    check_field("name_out", want.name, rsp_bus.name_out);
                    check_field("value_out", want.value, rsp_bus.value_out);
                    check_field("old_value", want.old_value, rsp_bus.old_value);
                    check_field("last", want.last, rsp_bus.last);
                end
            end
            case ((cycle_count / 300) % 4)
                0:       rsp_bus.ready <= 1'b1;
                1:       rsp_bus.ready <= ($urandom_range(0, 3) != 0);
                2:       rsp_bus.ready <= ($urandom_range(0, 1) != 0);
                default: rsp_bus.ready <= ((cycle_count % 7) < 2);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sorted_key_value_table_core_tb: errors");
            $finish;
        end
    end

    initial
    begin : stimulus
        int order[POOL_SIZE];
        int r;

        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // empty table
        queue_op(MODE_DUMP,   '0, '0, '0);
        queue_op(MODE_SEARCH, 32'd5, '0, '0);
        queue_op(MODE_DELETE, 32'd5, '0, '0);
        queue_op(MODE_UPDATE, 32'd5, '0, 32'h1234_5678);
        // names cut at a zero byte, at the length limit, and empty
        queue_op(MODE_INSERT, 32'h0000_0000, 64'h0000_0044_4300_4241, 32'h0000_0001);
        queue_op(MODE_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(MODE_INSERT, 32'h8000_0000, 64'h0, 32'h0);
        queue_op(MODE_INSERT, 32'h0000_0000, 64'h0102_0304_0506_0708, 32'hDEAD_BEEF);
        queue_op(MODE_UPDATE, 32'hFFFF_FFFF, '0, 32'h0);
        queue_op(MODE_SEARCH, 32'h8000_0000, '0, '0);
        queue_op(MODE_SEARCH, 32'h0000_0001, '0, '0);
        queue_op(3'd5, 32'h0000_0001, '1, '1);
        queue_op(3'd7, 32'hFFFF_FFFF, '1, '1);
        queue_op(MODE_DUMP,   '0, '0, '0);
        queue_op(MODE_DELETE, 32'h0000_0000, '0, '0);
        queue_op(MODE_DELETE, 32'hFFFF_FFFF, '0, '0);
        queue_op(MODE_DELETE, 32'h8000_0000, '0, '0);
        queue_op(MODE_DUMP,   '0, '0, '0);
        queue_op(MODE_INSERT, 32'h7FFF_FFFF, 64'h0123_4567_89AB_CDEF, 32'h5555_5555);
        queue_op(MODE_UPDATE, 32'h7FFF_FFFF, '0, 32'hAAAA_AAAA);
        queue_op(MODE_INSERT, 32'h0000_0001, 64'hFFFF_FFFF_FFFF_FF00, 32'h0F0F_0F0F);
        queue_op(MODE_DUMP,   '0, '0, '0);

        // fill past capacity
        shuffle_order(order);
        for (int i = 0; i < 34; i++)
            queue_op(MODE_INSERT, key_pool[order[i]], rand_name(), $urandom);
        queue_op(MODE_DUMP, '0, '0, '0);

        for (int i = 0; i < MIXED_OPS; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                queue_op(MODE_INSERT, pick_key(), rand_name(), $urandom);
            else if (r < 50)
                queue_op(MODE_DELETE, pick_key(), rand_name(), $urandom);
            else if (r < 65)
                queue_op(MODE_UPDATE, pick_key(), rand_name(), $urandom);
            else if (r < 85)
                queue_op(MODE_SEARCH, pick_key(), rand_name(), $urandom);
            else if (r < 92)
                queue_op(MODE_DUMP, $urandom, rand_name(), $urandom);
            else
                queue_op(3'($urandom_range(5, 7)), $urandom, rand_name(), $urandom);
        end

        // delete every pool key in shuffled order
        shuffle_order(order);
        for (int i = 0; i < POOL_SIZE; i++)
            queue_op(MODE_DELETE, key_pool[order[i]], rand_name(), $urandom);
        queue_op(MODE_DUMP, '0, '0, '0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || req_bus.valid)
            @(posedge clk);
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("sorted_key_value_table_core_tb: clean");
        else
            $display("sorted_key_value_table_core_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
